FILE: rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// Mesh frame deframer package
// Result codes, queue sizing and the command entry passed from the
// classifier to the result serializer.
// ----------------------------------------------------------------------------
package mfd_pkg;

    // Result kinds carried on the output channel.
    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_END      = 3'd1,
        KIND_ACK      = 3'd2,
        KIND_BADLEN   = 3'd3,
        KIND_OVERFLOW = 3'd4
    } kind_t;

    // Link constants.
    localparam logic [7:0] ACK_O    = 8'h4F;
    localparam logic [7:0] ACK_K    = 8'h4B;
    localparam logic [7:0] ACK_CR   = 8'h0D;
    localparam logic [7:0] ACK_LF   = 8'h0A;
    localparam logic [7:0] HDR_B0   = 8'hF1;
    localparam logic [7:0] HDR_B1   = 8'hDD;
    localparam logic [7:0] ID_LEN   = 8'd2;
    localparam logic [7:0] MIN_LEN  = 8'd4;
    localparam logic [8:0] FIRST_POS = 9'd4;
    localparam logic [8:0] BODY_POS  = 9'd7;

    // Register map.
    localparam int          PADDR_W       = 2;
    localparam logic [PADDR_W-1:0] ADDR_LINK_TYPE = 2'd0;

    // Queue between classifier and serializer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Up to four results per received byte.
    localparam int MAX_RES = 4;
    localparam int RIDX_W  = 2;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } result_t;

    typedef struct packed {
        logic [RIDX_W-1:0]          last_idx;
        result_t [MAX_RES-1:0]      res;
    } entry_t;

    // Queue head as seen by the serializer.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage

FILE: rtl/mfd_if.sv
// ----------------------------------------------------------------------------
// Mesh frame deframer channels
// Valid/ready stream interfaces for received bytes and for results.
// ----------------------------------------------------------------------------
interface mfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

FILE: rtl/mfd_front.sv
// ----------------------------------------------------------------------------
// Mesh frame deframer classifier
// Takes one received byte per cycle unless the queue is full, tracks hunt and
// frame state; each byte with results becomes one queue entry holding them all.
// ----------------------------------------------------------------------------
module mfd_front #(
    parameter int HOLD_DEPTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      link_type,
    mfd_in_if.sink          in_ch,
    input  logic            q_full,
    output logic            push,
    output mfd_pkg::entry_t push_entry
);
    import mfd_pkg::*;

    localparam int HC_W = $clog2(HOLD_DEPTH + 1);
    localparam logic [HC_W-1:0] HOLD_FULL = HC_W'(HOLD_DEPTH);
    localparam logic [HC_W-1:0] HC_ONE    = HC_W'(1);
    localparam logic [HC_W-1:0] HC_FOUR   = HC_W'(4);

    logic [23:0]     recent_reg, recent_next;
    logic [HC_W-1:0] held_reg, held_next;
    logic            in_frame_reg, in_frame_next;
    logic [8:0]      pos_reg, pos_next;
    logic [7:0]      len_reg, len_next;

    logic       accept;
    logic [7:0] b, b0, b1, b2;
    logic [HC_W-1:0] cnt;
    logic       data_en, frame_done;
    kind_t      end_kind;
    logic [2:0] n;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign b  = in_ch.rx_byte;
    assign b0 = recent_reg[23:16];
    assign b1 = recent_reg[15:8];
    assign b2 = recent_reg[7:0];
    assign cnt = held_reg + HC_ONE;

    // Frame body decode.
    assign data_en    = (len_reg >= MIN_LEN) && ((pos_reg == FIRST_POS) || (pos_reg >= BODY_POS));
    assign frame_done = pos_reg >= ({1'b0, len_reg} + 9'd2);
    assign end_kind   = (len_reg >= MIN_LEN) ? KIND_END : KIND_BADLEN;

    // Classify the byte and work out the next state.
    always_comb
    begin
        recent_next   = recent_reg;
        held_next     = held_reg;
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        push_entry    = '0;
        n             = 3'd0;

        if (held_reg >= HOLD_FULL)
        begin
            push_entry.res[0].kind = KIND_OVERFLOW;
            n = 3'd1;
        end
        else if (in_frame_reg)
        begin
            held_next = cnt;
            if (data_en)
            begin
                push_entry.res[0].kind  = KIND_DATA;
                push_entry.res[0].value = b;
                n = 3'd1;
            end
            if (frame_done)
            begin
                if (data_en)
                begin
                    push_entry.res[1].kind = end_kind;
                    n = 3'd2;
                end
                else
                begin
                    push_entry.res[0].kind = end_kind;
                    n = 3'd1;
                end
                in_frame_next = 1'b0;
                pos_next      = '0;
                len_next      = '0;
                held_next     = '0;
                recent_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + 9'd1;
            end
        end
        else
        begin
            // Hunting: shift the byte in unless a window match takes it.
            recent_next = {recent_reg[15:0], b};
            held_next   = cnt;
            if (cnt >= HC_FOUR)
            begin
                if ((b0 == ACK_O) && (b1 == ACK_K) && (b2 == ACK_CR) && (b == ACK_LF))
                begin
                    push_entry.res[0].kind = KIND_ACK;
                    n           = 3'd1;
                    recent_next = '0;
                    held_next   = '0;
                end
                else if ((b0 == HDR_B0) && (b1 == HDR_B1))
                begin
                    if (b2 >= MIN_LEN)
                    begin
                        push_entry.res[0].kind  = KIND_DATA;
                        push_entry.res[0].value = link_type;
                        push_entry.res[1].kind  = KIND_DATA;
                        push_entry.res[1].value = ID_LEN;
                        push_entry.res[2].kind  = KIND_DATA;
                        push_entry.res[2].value = b2 - MIN_LEN;
                        push_entry.res[3].kind  = KIND_DATA;
                        push_entry.res[3].value = b;
                        n = 3'd4;
                    end
                    if (b2 <= 8'd1)
                    begin
                        push_entry.res[0].kind = KIND_BADLEN;
                        n = 3'd1;
                        // A zero length byte keeps the new byte as first held byte.
                        if (b2 == 8'd0)
                        begin
                            held_next   = HC_ONE;
                            recent_next = {16'd0, b};
                        end
                        else
                        begin
                            held_next   = '0;
                            recent_next = '0;
                        end
                    end
                    else
                    begin
                        in_frame_next = 1'b1;
                        pos_next      = FIRST_POS;
                        len_next      = b2;
                        held_next     = HC_FOUR;
                        recent_next   = '0;
                    end
                end
            end
        end
        push_entry.last_idx = RIDX_W'(n - 3'd1);
    end

    assign push = accept && (n != 3'd0);

    // State registers, updated on each byte transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg   <= '0;
            held_reg     <= '0;
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            len_reg      <= '0;
        end
        else if (accept)
        begin
            recent_reg   <= recent_next;
            held_reg     <= held_next;
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
        end
    end

endmodule

FILE: rtl/mfd_fifo.sv
// ----------------------------------------------------------------------------
// Mesh frame deframer command queue
// Short register queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module mfd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mfd_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output mfd_pkg::head_t  head
);
    import mfd_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/mfd_back.sv
// ----------------------------------------------------------------------------
// Mesh frame deframer result serializer
// Sends the results of the queue head one per transfer and releases the
// entry after its last result.
// ----------------------------------------------------------------------------
module mfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  mfd_pkg::head_t head,
    output logic           pop,
    mfd_out_if.source      out_ch
);
    import mfd_pkg::*;

    logic [RIDX_W-1:0] idx_reg, idx_next;
    logic              is_last, xfer;
    result_t           cur;

    assign cur     = head.entry.res[idx_reg];
    assign is_last = (idx_reg == head.entry.last_idx);
    assign xfer    = head.valid && out_ch.ready;
    assign pop     = xfer && is_last;

    assign out_ch.valid = head.valid;
    assign out_ch.kind  = cur.kind;
    assign out_ch.value = cur.value;
    assign out_ch.last  = is_last;

    // Result index within the current entry.
    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

FILE: rtl/mesh_frame_deframer.sv
// ----------------------------------------------------------------------------
// Mesh frame deframer
// Byte-serial deframer for a mesh radio link: ack detection, header hunt,
// frame conversion, length and overflow errors.
//
//   Channel   Direction  Payload                  Handshake
//   in_ch     in         rx_byte[7:0]             valid / ready
//   out_ch    out        kind[2:0] value[7:0] last valid / ready
//   apb       in         link_type at address 0   psel / penable / pready
//
// A byte is classified in the cycle it is transferred; it gives one queue
// entry of up to four results, or none. The serializer sends one result per
// cycle while out_ch is ready; a byte with no results adds no entry. The
// classifier keeps taking bytes while the two-entry queue has room. Reset
// clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module mesh_frame_deframer #(
    parameter int HOLD_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    mfd_in_if.sink                       in_ch,
    mfd_out_if.source                    out_ch
);
    import mfd_pkg::*;

    logic [7:0] link_type_reg;
    logic       q_full, push, pop;
    entry_t     push_entry;
    head_t      head;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LINK_TYPE) ? {24'd0, link_type_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_type_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_LINK_TYPE))
        begin
            link_type_reg <= pwdata[7:0];
        end
    end

    // Classifier, queue and serializer.
    mfd_front #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_type  (link_type_reg),
        .in_ch      (in_ch),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mfd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head)
    );

    mfd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

FILE: rtl/mfd_checker.sv
// ----------------------------------------------------------------------------
// Mesh frame deframer checker
// Port-level properties of the result channel and the register port.
// ----------------------------------------------------------------------------
module mfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_kind,
    input logic [7:0] out_value,
    input logic       out_last
);
    import mfd_pkg::*;

    logic [1:0] run_reg, run_next;
    logic       xfer;

    assign xfer = out_valid && out_ready;

    // Results sent since the last one that closed a byte.
    always_comb
    begin
        run_next = run_reg;
        if (xfer)
        begin
            run_next = out_last ? 2'd0 : run_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    // Only data results carry a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != KIND_DATA) |-> (out_value == 8'd0))
        else $error("non-data result with nonzero value");

    // Every status result closes the results of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != KIND_DATA) |-> out_last)
        else $error("status result without last");

    // No byte causes more than four results.
    assert property (@(posedge clk) disable iff (!rst_n)
        xfer && (run_reg == 2'd3) |-> out_last)
        else $error("more than four results for one byte");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(out_value) && $stable(out_last))
        else $error("stalled result changed");

    // The register port never waits.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind mesh_frame_deframer mfd_checker u_mfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_value (out_ch.value),
    .out_last  (out_ch.last)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh frame deframer testbench
// Drives received link bytes and the link_type register. It predicts every
// result from a behavioral copy of the deframer and compares each result
// transfer in order. Covers acks, short and long frames, backpressure and
// random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import mfd_pkg::*;

    localparam int HOLD_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } deframed_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mfd_in_if  in_bus ();
    mfd_out_if out_bus ();

    mesh_frame_deframer #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (out_bus)
    );

    // Deframer state as the testbench sees it.
    logic [7:0]  type_byte_reg;
    logic [23:0] window_bytes;
    logic [10:0] held_total;
    logic        frame_open;
    logic [8:0]  next_raw_idx;
    logic [7:0]  len_byte;

    deframed_t   frame_results [$];
    deframed_t   want_result;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned bytes_sent     = 0;
    int unsigned idle_pct       = 0;
    int unsigned stall_pct      = 0;
    logic        hold_active    = 1'b0;
    event        hold_go;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void restart_hunt();
        frame_open   = 1'b0;
        next_raw_idx = '0;
        len_byte     = '0;
        held_total   = '0;
        window_bytes = '0;
    endfunction

    function automatic void add_result(input kind_t kind, input logic [7:0] value);
        deframed_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = 1'b0;
        frame_results = {frame_results, r};
    endfunction

    // Works out the results of one received byte and updates the state.
    function automatic void deframe_byte(input logic [7:0] b);
        int          first_new;
        logic [7:0]  w0;
        logic [7:0]  w1;
        logic [7:0]  w2;
        logic [10:0] cnt;
        logic [8:0]  p;
        logic [7:0]  len;
        logic        claimed;
        first_new = frame_results.size();
        w0        = window_bytes[23:16];
        w1        = window_bytes[15:8];
        w2        = window_bytes[7:0];
        claimed   = 1'b0;
        if (held_total >= HOLD_DEPTH)
        begin
            // Store full: the byte is dropped and flagged.
            add_result(KIND_OVERFLOW, 8'h00);
        end
        else if (frame_open)
        begin
            p   = next_raw_idx;
            len = len_byte;
            held_total = held_total + 1'b1;
            // Address bytes and payload pass through; bytes 5 and 6 are skipped.
            if (len >= MIN_LEN && (p == FIRST_POS || p >= BODY_POS))
                add_result(KIND_DATA, b);
            if (p >= {1'b0, len} + 9'd2)
            begin
                add_result((len >= MIN_LEN) ? KIND_END : KIND_BADLEN, 8'h00);
                restart_hunt();
            end
            else
            begin
                next_raw_idx = p + 9'd1;
            end
        end
        else
        begin
            cnt = held_total + 1'b1;
            if (cnt >= 11'd4)
            begin
                if (w0 == ACK_O && w1 == ACK_K && w2 == ACK_CR && b == ACK_LF)
                begin
                    add_result(KIND_ACK, 8'h00);
                    restart_hunt();
                    claimed = 1'b1;
                end
                else if (w0 == HDR_B0 && w1 == HDR_B1)
                begin
                    claimed = 1'b1;
                    if (w2 >= MIN_LEN)
                    begin
                        // Header seen: the converted frame opens with four bytes.
                        add_result(KIND_DATA, type_byte_reg);
                        add_result(KIND_DATA, ID_LEN);
                        add_result(KIND_DATA, w2 - MIN_LEN);
                        add_result(KIND_DATA, b);
                        frame_open   = 1'b1;
                        next_raw_idx = FIRST_POS;
                        len_byte     = w2;
                        held_total   = 11'd4;
                        window_bytes = '0;
                    end
                    else if (w2 <= 8'd1)
                    begin
                        // The window holds the whole short frame.
                        add_result(KIND_BADLEN, 8'h00);
                        restart_hunt();
                        if (w2 == 8'd0)
                        begin
                            held_total   = 11'd1;
                            window_bytes = {16'h0000, b};
                        end
                    end
                    else
                    begin
                        frame_open   = 1'b1;
                        next_raw_idx = FIRST_POS;
                        len_byte     = w2;
                        held_total   = 11'd4;
                        window_bytes = '0;
                    end
                end
            end
            if (!claimed)
            begin
                window_bytes = {window_bytes[15:0], b};
                held_total   = cnt;
            end
        end
        if (frame_results.size() > first_new)
            frame_results[frame_results.size() - 1].last = 1'b1;
    endfunction

    // Every accepted byte is run through the prediction.
    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
            deframe_byte(in_bus.rx_byte);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (frame_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result kind %0d value %02h last %0d",
                    out_bus.kind, out_bus.value, out_bus.last));
            end
            else
            begin
                want_result = frame_results.pop_front();
                if (out_bus.kind !== want_result.kind || out_bus.value !== want_result.value
                    || out_bus.last !== want_result.last)
                    note_mismatch($sformatf(
                        "expected kind %0d value %02h last %0d, got kind %0d value %02h last %0d",
                        want_result.kind, want_result.value, want_result.last,
                        out_bus.kind, out_bus.value, out_bus.last));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
        out_bus.ready <= !hold_active && ($urandom_range(99) >= stall_pct);

    always
    begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offers one byte and returns at the edge where it is transferred.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.rx_byte <= b;
        do
            @(posedge clk);
        while (in_bus.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_seq(input logic [7:0] seq [$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic send_header(input logic [7:0] len);
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_byte(len);
    endtask

    task automatic send_ack();
        send_byte(ACK_O);
        send_byte(ACK_K);
        send_byte(ACK_CR);
        send_byte(ACK_LF);
    endtask

    // Stops offering bytes so the prediction catches up.
    task automatic settle();
        in_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted result has come, then for the pipeline tail.
    task automatic drain();
        settle();
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_link_type(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LINK_TYPE;
        pwdata  <= {24'h000000, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        type_byte_reg = v;
    endtask

    // Mostly well-formed frames and acks, with noise and broken sequences.
    task automatic send_random_traffic(input int unsigned budget);
        int unsigned start_count;
        int unsigned pick;
        int unsigned len;
        start_count = bytes_sent;
        while (bytes_sent - start_count < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(255, 25)
                                                : $urandom_range(24, 4);
                send_header(len[7:0]);
                repeat (len) send_byte(8'($urandom_range(255)));
            end
            else if (pick < 70)
            begin
                len = $urandom_range(3, 0);
                send_header(len[7:0]);
                repeat ((len == 0) ? 1 : len) send_byte(8'($urandom_range(255)));
            end
            else if (pick < 80)
            begin
                send_ack();
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
            end
            else
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        send_byte(ACK_O);
                        send_byte(ACK_K);
                        send_byte(ACK_CR);
                    end
                    1:
                    begin
                        send_byte(HDR_B0);
                    end
                    default:
                    begin
                        send_byte(ACK_O);
                        send_byte(ACK_K);
                        send_byte(ACK_LF);
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Ack window straight out of reset, with the reset type byte in force.
    task automatic test_ack_after_reset();
        logic [7:0] seq [$];
        seq = {ACK_O, ACK_K, ACK_CR, ACK_LF};
        send_seq(seq);
    endtask

    // Length byte zero leaving its fourth byte as the start of a new header,
    // a length-five frame with extreme byte values, then length bytes one and two.
    task automatic test_short_lengths();
        logic [7:0] seq [$];
        seq = {HDR_B0, HDR_B1, 8'h00, HDR_B0, HDR_B1, 8'h05, 8'h00, 8'hBB, 8'hCC,
               8'hDD, 8'hFF,
               HDR_B0, HDR_B1, 8'h01, 8'h7E,
               HDR_B0, HDR_B1, 8'h02, 8'h81, 8'h18};
        send_seq(seq);
        drain();
    endtask

    // The longest frame the length byte allows.
    task automatic test_long_frame();
        drain();
        write_link_type(8'hFF);
        send_header(8'hFF);
        repeat (255) send_byte(8'($urandom_range(255)));
        drain();
    endtask

    // The receiver holds off while frames keep coming, so the input stalls.
    task automatic test_backpressure();
        drain();
        idle_pct  = 0;
        stall_pct = 0;
        ->hold_go;
        repeat (3)
        begin
            send_header(8'h08);
            repeat (8) send_byte(8'($urandom_range(255)));
        end
        send_ack();
        drain();
    endtask

    // Random traffic under each mix of sender idling and receiver stalls.
    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_link_type((ph == 1) ? 8'h00 : 8'($urandom_range(255)));
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            send_random_traffic(12);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        type_byte_reg  = 8'h00;
        restart_hunt();
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= ADDR_LINK_TYPE;
        pwdata         <= 32'h0;
        in_bus.valid   <= 1'b0;
        in_bus.rx_byte <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ack_after_reset();
        test_short_lengths();
        test_long_frame();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && frame_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
